// ===== hdl/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared constants and types for the LRU tag store.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int ENTRIES_DEF   = 8;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed field widths of the two channels.
    localparam int LOOKUP_W = 32;
    localparam int SLOT_W   = 3;
    localparam int EV_KEY_W = 32;

    // Outcome of one lookup.
    typedef struct packed {
        logic hit;
        logic evict;
    } lts_decision_t;

endpackage

// ===== hdl/lts_in_if.sv =====
// ----------------------------------------------------------------------------
// lts_in_if
// Lookup channel: valid/ready handshake carrying one lookup key.
// ----------------------------------------------------------------------------
interface lts_in_if;

    logic                         valid;
    logic                         ready;
    logic [lts_pkg::LOOKUP_W-1:0] lookup_key;

    modport source (output valid, output lookup_key, input ready);
    modport sink   (input valid, input lookup_key, output ready);

endinterface

// ===== hdl/lts_out_if.sv =====
// ----------------------------------------------------------------------------
// lts_out_if
// Result channel: valid/ready handshake carrying one lookup result.
// ----------------------------------------------------------------------------
interface lts_out_if;

    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [lts_pkg::SLOT_W-1:0]   slot;
    logic                         evicted;
    logic [lts_pkg::EV_KEY_W-1:0] evicted_key;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_key, output ready);

endinterface

// ===== hdl/lts_match.sv =====
// ----------------------------------------------------------------------------
// lts_match
// Parallel compare of one key against every entry, with free slot and
// least recent entry selection.
// ----------------------------------------------------------------------------
module lts_match #(
    parameter int ENTRIES   = lts_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH = lts_pkg::KEY_WIDTH_DEF
) (
    input  logic [KEY_WIDTH-1:0]          key,
    input  logic [ENTRIES-1:0]            valid_vec,
    input  logic [KEY_WIDTH-1:0]          keys [ENTRIES],
    input  logic [$clog2(ENTRIES)-1:0]    ranks [ENTRIES],
    output logic [ENTRIES-1:0]            match_oh,
    output logic [ENTRIES-1:0]            free_oh,
    output logic [ENTRIES-1:0]            old_oh,
    output logic [$clog2(ENTRIES)-1:0]    hit_rank,
    output logic [KEY_WIDTH-1:0]          old_key,
    output lts_pkg::lts_decision_t        decision
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam logic [RANK_W-1:0] OLDEST_RANK = RANK_W'(ENTRIES - 1);

    logic [ENTRIES-1:0] free_vec;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_oh[i] = valid_vec[i] && (keys[i] == key);
            // With every slot valid the ranks are a permutation, so the least
            // recent entry is the one holding the highest rank.
            old_oh[i]   = valid_vec[i] && (ranks[i] == OLDEST_RANK);
        end
    end

    assign free_vec = ~valid_vec;
    // Isolate the lowest-numbered free slot.
    assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));

    always_comb
    begin
        hit_rank = '0;
        old_key  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_oh[i])
            begin
                hit_rank = hit_rank | ranks[i];
            end
            if (old_oh[i])
            begin
                old_key = old_key | keys[i];
            end
        end
    end

    always_comb
    begin
        decision.hit   = |match_oh;
        decision.evict = !decision.hit && !(|free_vec);
    end

endmodule

// ===== hdl/lts_store.sv =====
// ----------------------------------------------------------------------------
// lts_store
// Entry registers: valid bits, keys and recency ranks, with the LRU update.
// ----------------------------------------------------------------------------
module lts_store #(
    parameter int ENTRIES   = lts_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH = lts_pkg::KEY_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          upd_en,
    input  lts_pkg::lts_decision_t        decision,
    input  logic [ENTRIES-1:0]            tgt_oh,
    input  logic [$clog2(ENTRIES)-1:0]    hit_rank,
    input  logic [KEY_WIDTH-1:0]          key,
    output logic [ENTRIES-1:0]            valid_vec,
    output logic [KEY_WIDTH-1:0]          keys [ENTRIES],
    output logic [$clog2(ENTRIES)-1:0]    ranks [ENTRIES]
);

    localparam int RANK_W = $clog2(ENTRIES);

    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [RANK_W-1:0]    rank_reg  [ENTRIES];
    logic [RANK_W-1:0]    rank_next [ENTRIES];
    logic [KEY_WIDTH-1:0] key_reg   [ENTRIES];

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (upd_en)
            begin
                if (tgt_oh[i])
                begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end
                else if (valid_reg[i] && (!decision.hit || rank_reg[i] < hit_rank))
                begin
                    // On a hit only the entries more recent than the hit one
                    // age; on an insert every other valid entry ages.
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rank_reg  <= '{default: '0};
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (upd_en && tgt_oh[i] && !decision.hit)
            begin
                key_reg[i] <= key;
            end
        end
    end

    assign valid_vec = valid_reg;
    assign keys      = key_reg;
    assign ranks     = rank_reg;

endmodule

// ===== hdl/lru_tag_store.sv =====
// ----------------------------------------------------------------------------
// lru_tag_store
// Fully associative tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  lookup    in         lookup_key
//  result    out        hit, slot, evicted, evicted_key
//
//  One lookup is taken per clock while lookup.ready is high. The accepting
//  edge loads a lookup into the input register; once the result register is
//  free, the lookup is taken through the parallel compare and LRU update
//  into the result register.
//  Reset clears all valid bits and ranks at once; no clearing pass follows.
//  While a result waits the input register holds one further lookup, then
//  lookup.ready falls until result.ready returns.
// ----------------------------------------------------------------------------
module lru_tag_store #(
    parameter int ENTRIES   = lts_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH = lts_pkg::KEY_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lts_in_if.sink    lookup,
    lts_out_if.source result
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int IDX_W  = $clog2(ENTRIES);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [KEY_WIDTH-1:0]          key_reg;
    logic                          step;

    logic [ENTRIES-1:0]            valid_vec;
    logic [KEY_WIDTH-1:0]          keys  [ENTRIES];
    logic [RANK_W-1:0]             ranks [ENTRIES];
    logic [ENTRIES-1:0]            match_oh;
    logic [ENTRIES-1:0]            free_oh;
    logic [ENTRIES-1:0]            old_oh;
    logic [ENTRIES-1:0]            tgt_oh;
    logic [RANK_W-1:0]             hit_rank;
    logic [KEY_WIDTH-1:0]          old_key;
    lts_pkg::lts_decision_t        decision;
    logic [IDX_W-1:0]              tgt_idx;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          hit_reg;
    logic [lts_pkg::SLOT_W-1:0]    slot_reg;
    logic                          evicted_reg;
    logic [lts_pkg::EV_KEY_W-1:0]  ev_key_reg;

    // The held lookup is processed whenever the result register is free.
    assign step         = in_valid_reg && (!out_valid_reg || result.ready);
    assign lookup.ready = !in_valid_reg || step;

    assign in_valid_next  = (lookup.valid && lookup.ready) ? 1'b1
                          : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup.valid && lookup.ready)
        begin
            key_reg <= KEY_WIDTH'(lookup.lookup_key);
        end
        if (step)
        begin
            hit_reg     <= decision.hit;
            slot_reg    <= lts_pkg::SLOT_W'(tgt_idx);
            evicted_reg <= decision.evict;
            ev_key_reg  <= decision.evict ? lts_pkg::EV_KEY_W'(old_key) : '0;
        end
    end

    lts_match #(
        .ENTRIES   (ENTRIES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_match (
        .key       (key_reg),
        .valid_vec (valid_vec),
        .keys      (keys),
        .ranks     (ranks),
        .match_oh  (match_oh),
        .free_oh   (free_oh),
        .old_oh    (old_oh),
        .hit_rank  (hit_rank),
        .old_key   (old_key),
        .decision  (decision)
    );

    assign tgt_oh = decision.hit ? match_oh : (decision.evict ? old_oh : free_oh);

    always_comb
    begin
        tgt_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tgt_oh[i])
            begin
                tgt_idx = tgt_idx | IDX_W'(i);
            end
        end
    end

    lts_store #(
        .ENTRIES   (ENTRIES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_en    (step),
        .decision  (decision),
        .tgt_oh    (tgt_oh),
        .hit_rank  (hit_rank),
        .key       (key_reg),
        .valid_vec (valid_vec),
        .keys      (keys),
        .ranks     (ranks)
    );

    assign result.valid       = out_valid_reg;
    assign result.hit         = hit_reg;
    assign result.slot        = slot_reg;
    assign result.evicted     = evicted_reg;
    assign result.evicted_key = ev_key_reg;

    // Stored keys are distinct, so a lookup never matches two entries.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> $onehot0(match_oh))
        else $error("lookup matched more than one entry");

    // A full store always has exactly one least recent entry.
    a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (step && decision.evict) |-> $onehot(old_oh))
        else $error("no unique victim in a full store");

    // Every processed lookup selects exactly one target slot.
    a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> $onehot(tgt_oh))
        else $error("target slot not unique");

    // A processed lookup is presented as a result on the next edge.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (out_valid_reg && hit_reg == $past(decision.hit)))
        else $error("result register not loaded");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU tag store. A table of directed lookups is
// run first, then random lookups drawn from working sets of varying size, so
// that hits, inserts into free slots and evictions all occur in volume. Each
// accepted lookup is predicted by an LRU model kept in the bench, and every
// result transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_LINES     = lts_pkg::ENTRIES_DEF;
    localparam int DIRECTED_ROWS = 21;
    localparam int RANDOM_ITEMS  = 1630;
    localparam int POOL_SIZE     = 16;
    localparam int HOLD_OFF      = 200;
    localparam int STALL_LIMIT   = 1000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic                         hit;
        logic [lts_pkg::SLOT_W-1:0]   slot;
        logic                         evicted;
        logic [lts_pkg::EV_KEY_W-1:0] evicted_key;
    } lookup_result_t;

    typedef struct {
        logic [lts_pkg::LOOKUP_W-1:0] key;
        bit                           typed;
        lookup_result_t               want;
    } directed_row_t;

    // Rows with typed set carry an outcome that follows directly from the
    // fill order; the rest are checked against the LRU model only.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 1'b1, '{1'b0, 3'd0, 1'b0, 32'h0000_0000}},
        '{32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 32'h0000_0000}},
        '{32'h0000_0000, 1'b1, '{1'b1, 3'd0, 1'b0, 32'h0000_0000}},
        '{32'h0000_0001, 1'b1, '{1'b0, 3'd2, 1'b0, 32'h0000_0000}},
        '{32'h0000_0002, 1'b1, '{1'b0, 3'd3, 1'b0, 32'h0000_0000}},
        '{32'h0000_0004, 1'b1, '{1'b0, 3'd4, 1'b0, 32'h0000_0000}},
        '{32'h0000_0008, 1'b1, '{1'b0, 3'd5, 1'b0, 32'h0000_0000}},
        '{32'h0000_0010, 1'b1, '{1'b0, 3'd6, 1'b0, 32'h0000_0000}},
        '{32'h0000_0020, 1'b1, '{1'b0, 3'd7, 1'b0, 32'h0000_0000}},
        '{32'hFFFF_FFFF, 1'b1, '{1'b1, 3'd1, 1'b0, 32'h0000_0000}},
        '{32'hDEAD_BEEF, 1'b1, '{1'b0, 3'd0, 1'b1, 32'h0000_0000}},
        '{32'hA5A5_A5A5, 1'b1, '{1'b0, 3'd2, 1'b1, 32'h0000_0001}},
        '{32'h0000_0001, 1'b1, '{1'b0, 3'd3, 1'b1, 32'h0000_0002}},
        '{32'h0000_0001, 1'b0, '0},
        '{32'h0000_0004, 1'b0, '0},
        '{32'h8000_0000, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'h0000_0000, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0}
    };

    logic clk;
    logic rst_n = 1'b0;

    lts_in_if  lookup ();
    lts_out_if result ();

    lru_tag_store dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .lookup (lookup),
        .result (result)
    );

    // Model of the tag store contents.
    bit                           line_valid [NUM_LINES];
    logic [lts_pkg::LOOKUP_W-1:0] line_key   [NUM_LINES];
    int                           line_rank  [NUM_LINES];

    lookup_result_t pending_outcomes [$];
    int             fail_count   = 0;
    int             results_seen = 0;
    int             stall_cycles = 0;
    bit             sender_steady = 1'b0;
    bit             held_off      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Every valid line more recent than the limit becomes one step older.
    function automatic void age_lines(int limit);
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (line_valid[i] && line_rank[i] < limit)
                line_rank[i]++;
        end
    endfunction

    function automatic lookup_result_t predict_lookup(logic [lts_pkg::LOOKUP_W-1:0] key);
        lookup_result_t outcome;
        int match;
        int free_line;
        int oldest;
        int target;
        outcome   = '0;
        match     = -1;
        free_line = -1;
        oldest    = -1;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (line_valid[i])
            begin
                if (match < 0 && line_key[i] == key)
                    match = i;
                if (oldest < 0 || line_rank[i] > line_rank[oldest])
                    oldest = i;
            end
            else if (free_line < 0)
            begin
                free_line = i;
            end
        end
        if (match >= 0)
        begin
            outcome.hit  = 1'b1;
            outcome.slot = match[lts_pkg::SLOT_W-1:0];
            age_lines(line_rank[match]);
            line_rank[match] = 0;
        end
        else
        begin
            if (free_line >= 0)
            begin
                target = free_line;
            end
            else
            begin
                target              = oldest;
                outcome.evicted     = 1'b1;
                outcome.evicted_key = line_key[target];
                line_valid[target]  = 1'b0;
            end
            age_lines(NUM_LINES);
            line_valid[target] = 1'b1;
            line_key[target]   = key;
            line_rank[target]  = 0;
            outcome.slot       = target[lts_pkg::SLOT_W-1:0];
        end
        return outcome;
    endfunction

    // Offers one lookup and records its outcome once the transaction is taken.
    task automatic send_lookup(input logic [lts_pkg::LOOKUP_W-1:0] key, input bit typed,
                               input lookup_result_t typed_want);
        lookup_result_t predicted;
        if (!sender_steady)
        begin
            while ($urandom_range(99) < 32)
            begin
                lookup.valid <= 1'b0;
                @(posedge clk);
            end
        end
        lookup.valid      <= 1'b1;
        lookup.lookup_key <= key;
        do
            @(posedge clk);
        while (!lookup.ready);
        predicted = predict_lookup(key);
        pending_outcomes.push_back(typed ? typed_want : predicted);
    endtask

    initial
    begin
        logic [lts_pkg::LOOKUP_W-1:0] key;
        logic [lts_pkg::LOOKUP_W-1:0] key_pool [POOL_SIZE];
        int pick;
        int working;
        lookup.valid      <= 1'b0;
        lookup.lookup_key <= '0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_lookup(directed_rows[r].key, directed_rows[r].typed, directed_rows[r].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Small working sets give mostly hits, large ones mostly evictions.
            working       = 4 + (n / 150) % 13;
            sender_steady = (n >= 700 && n < 1000);
            pick          = $urandom_range(99);
            if (pick < 60)
            begin
                key = key_pool[$urandom_range(working - 1)];
            end
            else if (pick < 65)
            begin
                key = $urandom_range(1) ? '1 : '0;
            end
            else
            begin
                key = $urandom;
                key_pool[$urandom_range(POOL_SIZE - 1)] = key;
            end
            send_lookup(key, 1'b0, '0);
        end
        lookup.valid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Receiver: random back-pressure, one long hold-off that fills the block,
    // and a stretch with ready held high.
    initial
    begin
        result.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && results_seen >= 300)
            begin
                held_off = 1'b1;
                result.ready <= 1'b0;
                for (int k = 0; k < HOLD_OFF; k++)
                    @(posedge clk);
            end
            else if (results_seen >= 700 && results_seen < 1000)
            begin
                result.ready <= 1'b1;
            end
            else
            begin
                result.ready <= ($urandom_range(99) >= 32);
            end
        end
    end

    always @(posedge clk)
    begin
        lookup_result_t want;
        lookup_result_t got;
        if (rst_n && result.valid && result.ready)
        begin
            results_seen++;
            got = '{result.hit, result.slot, result.evicted, result.evicted_key};
            if (pending_outcomes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%t: result transaction with no lookup outstanding: %p",
                             $realtime, got);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"%t: mismatch: expected hit=%0b slot=%0d evicted=%0b ",
                                  "evicted_key=%08h, got hit=%0b slot=%0d evicted=%0b ",
                                  "evicted_key=%08h"},
                                 $realtime, want.hit, want.slot, want.evicted,
                                 want.evicted_key, got.hit, got.slot, got.evicted,
                                 got.evicted_key);
                end
            end
        end
    end

    // Ends the run if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (lookup.valid && lookup.ready) || (result.valid && result.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
hdl/lts_pkg.sv
hdl/lts_in_if.sv
hdl/lts_out_if.sv
hdl/lts_match.sv
hdl/lts_store.sv
hdl/lru_tag_store.sv
test/testbench.sv
